// ===== rtl/hpm_pkg.sv =====
// hpm_pkg: shared types, widths, register codes and reset values
// for the homography point map core; no dependencies
package hpm_pkg;

    localparam int COEF_WIDTH_DEF    = 32;
    localparam int OUT_FRAC_BITS_DEF = 12;

    localparam int CW_MAX  = 32;
    localparam int PROD_W  = CW_MAX + 17;
    localparam int SUM_W   = CW_MAX + 19;
    localparam int QUO_W   = 33;
    localparam int QDEPTH  = 4;

    localparam logic [63:0] PAIR_A_RST = 64'h0001_0000_0000_0000;
    localparam logic [63:0] PAIR_B_RST = 64'h0;
    localparam logic [63:0] PAIR_C_RST = 64'h0001_0000_0000_0000;
    localparam logic [63:0] PAIR_D_RST = 64'h0;
    localparam logic [63:0] PAIR_E_RST = 64'h0001_0000_0000_0001;
    localparam logic [31:0] FRAME_RST  = 32'd125830200;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        REG_PAIR_A = 3'd0,
        REG_PAIR_B = 3'd1,
        REG_PAIR_C = 3'd2,
        REG_PAIR_D = 3'd3,
        REG_PAIR_E = 3'd4,
        REG_FRAME  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [63:0] pa;
        logic [63:0] pb;
        logic [63:0] pc;
        logic [63:0] pd;
        logic [63:0] pe;
    } t_coef;

    typedef struct packed {
        logic [SUM_W-1:0] un;
        logic [SUM_W-1:0] vn;
        logic [SUM_W-1:0] zd;
        logic             neg_x;
        logic             neg_y;
        logic             pvalid;
        logic             first;
        logic             last;
    } t_item;

endpackage

// ===== rtl/hpm_front.sv =====
// hpm_front: accepts points, forms u, v, z and classifies z against epsilon
// depends on hpm_pkg
module hpm_front #(
    parameter int COEF_WIDTH = hpm_pkg::COEF_WIDTH_DEF,
    parameter int QDEPTH     = hpm_pkg::QDEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  hpm_pkg::t_coef             i_coef,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [15:0]                i_x_in,
    input  logic [15:0]                i_y_in,
    input  logic                       i_first_of_set,
    input  logic                       i_last_of_set,
    input  logic [$clog2(QDEPTH+1)-1:0] i_level,
    output logic                       o_push,
    output hpm_pkg::t_item             o_item
);

    localparam int CWE = (COEF_WIDTH > hpm_pkg::CW_MAX) ? hpm_pkg::CW_MAX : COEF_WIDTH;
    localparam int SW  = hpm_pkg::SUM_W;
    localparam int PW  = hpm_pkg::PROD_W;
    localparam int LW  = $clog2(QDEPTH+1);

    function automatic logic signed [31:0] coef(input logic [31:0] half);
        logic [31:0] t;
        t = half << (32 - CWE);
        return $signed(t) >>> (32 - CWE);
    endfunction

    logic signed [PW-1:0] r_pu0, r_pu1, r_pv0, r_pv1, r_pz0, r_pz1;
    logic signed [35:0]   r_ku, r_kv, r_kz;
    logic                 r_f1, r_l1;
    logic                 r_s1v, r_s2v;
    hpm_pkg::t_item       r_it;

    logic                 accept;
    logic [LW+1:0]        occ;
    logic signed [16:0]   xs, ys;
    logic signed [SW-1:0] su, sv, sz;
    logic [SW-1:0]        eps_ext;
    hpm_pkg::t_item       n_it;

    assign occ        = (LW+2)'(i_level) + (LW+2)'(r_s1v) + (LW+2)'(r_s2v);
    assign o_in_stall = occ >= (LW+2)'(QDEPTH);
    assign accept     = i_in_valid && !o_in_stall;
    assign xs         = $signed({1'b0, i_x_in});
    assign ys         = $signed({1'b0, i_y_in});

    always_comb begin
        su = SW'(r_pu0) + SW'(r_pu1) + SW'(r_ku);
        sv = SW'(r_pv0) + SW'(r_pv1) + SW'(r_kv);
        sz = SW'(r_pz0) + SW'(r_pz1) + SW'(r_kz);
        eps_ext = SW'({i_coef.pe[31:0], 4'b0000});
        n_it.un     = su[SW-1] ? SW'(-su) : SW'(su);
        n_it.vn     = sv[SW-1] ? SW'(-sv) : SW'(sv);
        n_it.zd     = sz[SW-1] ? SW'(-sz) : SW'(sz);
        n_it.neg_x  = su[SW-1] != sz[SW-1];
        n_it.neg_y  = sv[SW-1] != sz[SW-1];
        n_it.pvalid = n_it.zd > eps_ext;
        n_it.first  = r_f1;
        n_it.last   = r_l1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v <= 1'b0;
            r_s2v <= 1'b0;
        end else begin
            r_s1v <= accept;
            r_s2v <= r_s1v;
        end
        r_pu0 <= PW'(coef(i_coef.pa[63:32]) * xs);
        r_pu1 <= PW'(coef(i_coef.pa[31:0]) * ys);
        r_pv0 <= PW'(coef(i_coef.pb[31:0]) * xs);
        r_pv1 <= PW'(coef(i_coef.pc[63:32]) * ys);
        r_pz0 <= PW'(coef(i_coef.pd[63:32]) * xs);
        r_pz1 <= PW'(coef(i_coef.pd[31:0]) * ys);
        r_ku  <= {coef(i_coef.pb[63:32]), 4'b0000};
        r_kv  <= {coef(i_coef.pc[31:0]), 4'b0000};
        r_kz  <= {coef(i_coef.pe[63:32]), 4'b0000};
        r_f1  <= i_first_of_set;
        r_l1  <= i_last_of_set;
        r_it  <= n_it;
    end

    assign o_push = r_s2v;
    assign o_item = r_it;

endmodule

// ===== rtl/hpm_queue.sv =====
// hpm_queue: short request queue between front and back
// depends on hpm_pkg
module hpm_queue #(
    parameter int QDEPTH = hpm_pkg::QDEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  hpm_pkg::t_item              i_item,
    input  logic                        i_pop,
    output hpm_pkg::t_item              o_item,
    output logic                        o_empty,
    output logic [$clog2(QDEPTH+1)-1:0] o_level
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int LW    = $clog2(QDEPTH+1);

    hpm_pkg::t_item r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [LW-1:0]    r_cnt;

    function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QDEPTH-1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= nxt(r_wp);
            if (i_pop) r_rp <= nxt(r_rp);
            r_cnt <= r_cnt + LW'(i_push) - LW'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_item;
    end

    assign o_item  = r_mem[r_rp];
    assign o_empty = r_cnt == '0;
    assign o_level = r_cnt;

endmodule

// ===== rtl/hpm_back.sv =====
// hpm_back: serial divide, saturation, box update and result register
// depends on hpm_pkg
module hpm_back #(
    parameter int OUT_FRAC_BITS = hpm_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [31:0]         i_frame,
    input  logic                i_empty,
    input  hpm_pkg::t_item      i_item,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [31:0]  o_out_x,
    output logic signed [31:0]  o_out_y,
    output logic                o_point_valid,
    output logic signed [31:0]  o_box_left,
    output logic signed [31:0]  o_box_top,
    output logic signed [31:0]  o_box_right,
    output logic signed [31:0]  o_box_bottom,
    output logic                o_overlap
);

    localparam int F    = OUT_FRAC_BITS;
    localparam int SW   = hpm_pkg::SUM_W;
    localparam int QW   = hpm_pkg::QUO_W;
    localparam int NW   = SW + F;
    localparam int RW   = SW + 1;
    localparam int CMPW = SW + QW;
    localparam int CNTW = $clog2(QW);
    localparam int LIMW = 16 + F;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_DIV, S_SAT, S_BOX, S_FIN
    } t_state;

    t_state           r_state;
    hpm_pkg::t_item   r_it;
    logic [RW-1:0]    r_rx, r_ry;
    logic [QW-1:0]    r_lx, r_ly, r_qx, r_qy;
    logic             r_ovx, r_ovy;
    logic [CNTW-1:0]  r_cnt;
    logic signed [31:0] r_ox, r_oy;
    logic signed [31:0] r_min_c, r_min_r, r_max_c, r_max_r;
    logic             r_ov;

    logic [NW-1:0]    nx, ny;
    logic [CMPW-1:0]  dsh;
    logic [RW-1:0]    tx, ty, dext;
    logic             gx, gy;
    logic signed [31:0] bmin_c, bmin_r, bmax_c, bmax_r;
    logic signed [31:0] wlim, hlim, left, top, right, bottom;
    logic [LIMW-1:0]  wl, hl;
    logic             out_free;

    function automatic logic signed [31:0] sat(input logic neg, input logic ovf,
                                               input logic [QW-1:0] q);
        logic [QW:0] m;
        m = {1'b0, q};
        if (neg) begin
            if (ovf || q > QW'(33'h0_8000_0000)) return hpm_pkg::S32_MIN;
            m = -m;
            return $signed(m[31:0]);
        end
        if (ovf || q > QW'(33'h0_7FFF_FFFF)) return hpm_pkg::S32_MAX;
        return $signed(q[31:0]);
    endfunction

    function automatic logic signed [31:0] lim(input logic [LIMW-1:0] v);
        return (LIMW'(v) > LIMW'(32'h7FFF_FFFF)) ? hpm_pkg::S32_MAX : $signed(32'(v));
    endfunction

    always_comb begin
        nx   = NW'(r_it.un) << F;
        ny   = NW'(r_it.vn) << F;
        dsh  = CMPW'(r_it.zd) << (QW - F);
        dext = RW'(r_it.zd);
        tx   = {r_rx[RW-2:0], r_lx[QW-1]};
        ty   = {r_ry[RW-2:0], r_ly[QW-1]};
        gx   = tx >= dext;
        gy   = ty >= dext;
        bmin_c = r_it.first ? hpm_pkg::S32_MAX : r_min_c;
        bmin_r = r_it.first ? hpm_pkg::S32_MAX : r_min_r;
        bmax_c = r_it.first ? hpm_pkg::S32_MIN : r_max_c;
        bmax_r = r_it.first ? hpm_pkg::S32_MIN : r_max_r;
        wl     = LIMW'(i_frame[31:16]) << F;
        hl     = LIMW'(i_frame[15:0]) << F;
        wlim   = lim(wl);
        hlim   = lim(hl);
        left   = (r_min_c > 0) ? r_min_c : 32'sd0;
        top    = (r_min_r > 0) ? r_min_r : 32'sd0;
        right  = (r_max_c < wlim) ? r_max_c : wlim;
        bottom = (r_max_r < hlim) ? r_max_r : hlim;
        out_free = !r_ov || !i_out_stall;
    end

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_min_c <= hpm_pkg::S32_MAX;
            r_min_r <= hpm_pkg::S32_MAX;
            r_max_c <= hpm_pkg::S32_MIN;
            r_max_r <= hpm_pkg::S32_MIN;
        end else begin
            r_ov <= ((r_state == S_FIN) && out_free) || (r_ov && i_out_stall);
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_it    <= i_item;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (!r_it.pvalid) begin
                        r_ox    <= 32'sd0;
                        r_oy    <= 32'sd0;
                        r_state <= S_BOX;
                    end else begin
                        r_ovx   <= CMPW'(r_it.un) >= dsh;
                        r_ovy   <= CMPW'(r_it.vn) >= dsh;
                        r_rx    <= RW'(nx >> QW);
                        r_ry    <= RW'(ny >> QW);
                        r_lx    <= nx[QW-1:0];
                        r_ly    <= ny[QW-1:0];
                        r_cnt   <= CNTW'(QW - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rx <= gx ? tx - dext : tx;
                    r_ry <= gy ? ty - dext : ty;
                    r_lx <= {r_lx[QW-2:0], 1'b0};
                    r_ly <= {r_ly[QW-2:0], 1'b0};
                    r_qx <= {r_qx[QW-2:0], gx};
                    r_qy <= {r_qy[QW-2:0], gy};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) r_state <= S_SAT;
                end
                S_SAT: begin
                    r_ox    <= sat(r_it.neg_x, r_ovx, r_qx);
                    r_oy    <= sat(r_it.neg_y, r_ovy, r_qy);
                    r_state <= S_BOX;
                end
                S_BOX: begin
                    r_min_c <= (r_it.pvalid && r_ox < bmin_c) ? r_ox : bmin_c;
                    r_min_r <= (r_it.pvalid && r_oy < bmin_r) ? r_oy : bmin_r;
                    r_max_c <= (r_it.pvalid && r_ox > bmax_c) ? r_ox : bmax_c;
                    r_max_r <= (r_it.pvalid && r_oy > bmax_r) ? r_oy : bmax_r;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        o_out_x       <= r_ox;
                        o_out_y       <= r_oy;
                        o_point_valid <= r_it.pvalid;
                        o_box_left    <= r_it.last ? left : 32'sd0;
                        o_box_top     <= r_it.last ? top : 32'sd0;
                        o_box_right   <= r_it.last ? right : 32'sd0;
                        o_box_bottom  <= r_it.last ? bottom : 32'sd0;
                        o_overlap     <= r_it.last && (left < right) && (top < bottom);
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ov;

endmodule

// ===== rtl/homography_point_map_with_overlap_box_core.sv =====
// homography_point_map_with_overlap_box_core: the back end finishes one item before it pops
// another (request pop, check, one-bit-per-cycle divider, saturate, box, result, held while
// the output stalls); an invalid point skips the divider and the saturate step
// the front takes up to 4 requests ahead while the back end divides
// synchronous active-low reset: identity homography, epsilon 2^-16, 1920x1080, empty box
module homography_point_map_with_overlap_box_core #(
    parameter int COEF_WIDTH    = hpm_pkg::COEF_WIDTH_DEF,
    parameter int OUT_FRAC_BITS = hpm_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [15:0]        i_x_in,
    input  logic [15:0]        i_y_in,
    input  logic               i_first_of_set,
    input  logic               i_last_of_set,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic               o_point_valid,
    output logic signed [31:0] o_box_left,
    output logic signed [31:0] o_box_top,
    output logic signed [31:0] o_box_right,
    output logic signed [31:0] o_box_bottom,
    output logic               o_overlap
);

    localparam int QD = hpm_pkg::QDEPTH;
    localparam int LW = $clog2(QD+1);

    hpm_pkg::t_coef r_coef;
    logic [31:0]    r_frame;

    logic           push, pop, empty;
    hpm_pkg::t_item f_item, q_item;
    logic [LW-1:0]  level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef.pa <= hpm_pkg::PAIR_A_RST;
            r_coef.pb <= hpm_pkg::PAIR_B_RST;
            r_coef.pc <= hpm_pkg::PAIR_C_RST;
            r_coef.pd <= hpm_pkg::PAIR_D_RST;
            r_coef.pe <= hpm_pkg::PAIR_E_RST;
            r_frame   <= hpm_pkg::FRAME_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hpm_pkg::REG_PAIR_A: r_coef.pa <= i_cfg_data;
                hpm_pkg::REG_PAIR_B: r_coef.pb <= i_cfg_data;
                hpm_pkg::REG_PAIR_C: r_coef.pc <= i_cfg_data;
                hpm_pkg::REG_PAIR_D: r_coef.pd <= i_cfg_data;
                hpm_pkg::REG_PAIR_E: r_coef.pe <= i_cfg_data;
                hpm_pkg::REG_FRAME:  r_frame   <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    hpm_front #(.COEF_WIDTH(COEF_WIDTH), .QDEPTH(QD)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_coef(r_coef),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_x_in(i_x_in), .i_y_in(i_y_in),
        .i_first_of_set(i_first_of_set), .i_last_of_set(i_last_of_set),
        .i_level(level), .o_push(push), .o_item(f_item)
    );

    hpm_queue #(.QDEPTH(QD)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_item(f_item),
        .i_pop(pop), .o_item(q_item), .o_empty(empty), .o_level(level)
    );

    hpm_back #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_frame(r_frame),
        .i_empty(empty), .i_item(q_item), .o_pop(pop),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_out_x(o_out_x), .o_out_y(o_out_y), .o_point_valid(o_point_valid),
        .o_box_left(o_box_left), .o_box_top(o_box_top),
        .o_box_right(o_box_right), .o_box_bottom(o_box_bottom),
        .o_overlap(o_overlap)
    );

`ifndef SYNTH
    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        level <= LW'(QD))
        else $error("queue overfilled");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (level == LW'(QD)) |-> o_in_stall)
        else $error("accepting with full queue");
    a_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_point_valid) |-> (o_out_x == 0 && o_out_y == 0))
        else $error("invalid point with nonzero coordinates");
    a_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overlap) |-> (o_box_left < o_box_right && o_box_top < o_box_bottom))
        else $error("overlap set on empty box");
`endif

endmodule
